FILE: hw/rtl/binary_neighbour_noise_filter_top_assert.svh
// assertion macros for the binary neighbour noise filter checker
`ifndef BINARY_NEIGHBOUR_NOISE_FILTER_TOP_ASSERT_SVH
`define BINARY_NEIGHBOUR_NOISE_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define BNNF_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bnnf assertion failed");

// next-cycle implication
`define BNNF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bnnf assertion failed");

`endif

FILE: hw/rtl/bnnf_pkg.sv
// shared types and constants of the binary neighbour noise filter
package bnnf_pkg;

   localparam int unsigned PIX_W     = 24;
   localparam int unsigned CH_W      = 8;
   localparam int unsigned COL_OUT_W = 10;
   localparam int unsigned ROW_W     = 16;
   localparam int unsigned CSR_W     = 16;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_THRESHOLD    = 2'd2,
      REG_MAX_DIFF     = 2'd3
   } reg_index_type;

   // 3x3 binary window: col0 oldest column; bits 2:0 top row, 5:3 middle, 8:6 bottom
   typedef struct packed {
      logic [8:0]       col0;
      logic [8:0]       col1;
      logic [8:0]       col2;
      logic [PIX_W-1:0] orig;
   } window_type;

endpackage

FILE: hw/rtl/bnnf_ram.sv
// generic single-port-write, registered-read ram
module bnnf_ram #(
   parameter int unsigned WIDTH = 30,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bnnf_filter.sv
// per-channel neighbour mean and outlier replacement for one window
module bnnf_filter (
   input  bnnf_pkg::window_type              win,
   input  logic [bnnf_pkg::CH_W-1:0]         max_diff,
   output logic [bnnf_pkg::PIX_W-1:0]        filtered
);

   function automatic logic [bnnf_pkg::CH_W-1:0] channel_mean(input logic [3:0] cnt);
      logic [11:0] prod;
      prod = {cnt, 8'h00} - {8'h00, cnt};
      return prod[10:3];
   endfunction

   always_comb begin
      logic [3:0]                cnt;
      logic [bnnf_pkg::CH_W-1:0] mean;
      logic [bnnf_pkg::CH_W-1:0] val;
      logic [bnnf_pkg::CH_W-1:0] diff;
      filtered = '0;
      for (int ch = 0; ch < 3; ch++) begin
         // eight neighbours, center of col1 excluded
         cnt = 4'(win.col0[ch]) + 4'(win.col0[3+ch]) + 4'(win.col0[6+ch])
             + 4'(win.col1[ch]) + 4'(win.col1[6+ch])
             + 4'(win.col2[ch]) + 4'(win.col2[3+ch]) + 4'(win.col2[6+ch]);
         mean = channel_mean(cnt);
         val  = win.orig[ch*8 +: 8];
         diff = (mean > val) ? (mean - val) : (val - mean);
         filtered[ch*8 +: 8] = (diff > max_diff) ? mean : val;
      end
   end

endmodule

FILE: hw/rtl/binary_neighbour_noise_filter_top.sv
// top level of the binary neighbour noise filter
//
// Takes one raster-order RGB pixel per clock while req_stall is low and emits pixels,
// filtered inside the frame and original at its border, with column and row, one per
// clock while rsp_stall is low. Each pixel does one read-modify-write of its column entry
// in a single line ram (two binarized rows plus one original row per column): the read
// is issued when the pixel is accepted and the write-back when it leaves stage 1, so a new
// pixel is taken as the last one is written back. A pixel whose window completes one
// result holds the input only while the output stalls; the last pixel of a row and pixels
// of the last row add one result each and hold the input until the extra results are sent,
// as the result port carries one transaction per clock. The line ram needs no clearing
// after reset or a resize: every entry that feeds a result is rewritten by the current
// frame before it is read. A write to image_width or image_height restarts the frame at column 0, row 0.
module binary_neighbour_noise_filter_top #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bnnf_pkg::CH_W-1:0]         req_in_red,
   input  logic [bnnf_pkg::CH_W-1:0]         req_in_green,
   input  logic [bnnf_pkg::CH_W-1:0]         req_in_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bnnf_pkg::CH_W-1:0]         rsp_out_red,
   output logic [bnnf_pkg::CH_W-1:0]         rsp_out_green,
   output logic [bnnf_pkg::CH_W-1:0]         rsp_out_blue,
   output logic [bnnf_pkg::COL_OUT_W-1:0]    rsp_out_column,
   output logic [bnnf_pkg::ROW_W-1:0]        rsp_out_row,
   output logic                              rsp_frame_last,
   input  logic                              csr_wr_en,
   input  bnnf_pkg::reg_index_type           csr_index,
   input  logic [bnnf_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int unsigned CW    = $clog2(MAX_WIDTH);
   localparam int unsigned WORD_W = 6 + bnnf_pkg::PIX_W;

   // configuration
   logic [10:0]                 width_ff;
   logic [bnnf_pkg::ROW_W-1:0]  height_ff;
   logic [bnnf_pkg::CH_W-1:0]   thresh_ff;
   logic [bnnf_pkg::CH_W-1:0]   max_diff_ff;
   logic                        resize;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 11'd640;
         height_ff   <= 16'd480;
         thresh_ff   <= 8'd100;
         max_diff_ff <= 8'd150;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bnnf_pkg::REG_IMAGE_WIDTH:  width_ff    <= csr_wdata[10:0];
            bnnf_pkg::REG_IMAGE_HEIGHT: height_ff   <= csr_wdata[15:0];
            bnnf_pkg::REG_THRESHOLD:    thresh_ff   <= csr_wdata[7:0];
            bnnf_pkg::REG_MAX_DIFF:     max_diff_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign resize = csr_wr_en && ((csr_index == bnnf_pkg::REG_IMAGE_WIDTH)
                              || (csr_index == bnnf_pkg::REG_IMAGE_HEIGHT));

   logic [CW-1:0]              col_last;
   logic [bnnf_pkg::ROW_W-1:0] row_last;

   always_comb begin
      if (width_ff < 11'd3) begin
         col_last = CW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         col_last = CW'(MAX_WIDTH - 1);
      end else begin
         col_last = CW'(width_ff - 11'd1);
      end
      row_last = (height_ff < 16'd3) ? 16'd2 : (height_ff - 16'd1);
   end

   // position counters
   logic [CW-1:0]              col_ff;
   logic [bnnf_pkg::ROW_W-1:0] row_ff;
   logic                       req_accept;

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset || resize) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (col_ff >= col_last) begin
            col_ff <= '0;
            row_ff <= (row_ff >= row_last) ? '0 : (row_ff + 16'd1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // stage 1: pixel waiting for its line ram word
   logic                        s1_valid_ff;
   logic [bnnf_pkg::PIX_W-1:0]  s1_pix_ff;
   logic [2:0]                  s1_bin_ff;
   logic [CW-1:0]               s1_col_ff;
   logic [bnnf_pkg::ROW_W-1:0]  s1_row_ff;
   logic                        s1_adv;

   logic [2:0]                  bin_in;
   assign bin_in = {req_in_blue > thresh_ff, req_in_green > thresh_ff, req_in_red > thresh_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         s1_pix_ff <= {req_in_blue, req_in_green, req_in_red};
         s1_bin_ff <= bin_in;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
   end

   // line ram word: slot 1 binary, slot 0 binary, original pixel
   logic [WORD_W-1:0] rd_word;
   logic [WORD_W-1:0] wr_word;
   logic [2:0]        slot0;
   logic [2:0]        slot1;
   logic [bnnf_pkg::PIX_W-1:0] above_pix;

   assign slot1     = rd_word[WORD_W-1 -: 3];
   assign slot0     = rd_word[WORD_W-4 -: 3];
   assign above_pix = rd_word[bnnf_pkg::PIX_W-1:0];
   assign wr_word   = s1_row_ff[0] ? {s1_bin_ff, slot0, s1_pix_ff}
                                   : {slot1, s1_bin_ff, s1_pix_ff};

   // consecutive pixels touch different columns, so a read never meets a pending write
   bnnf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (rd_word),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word)
   );

   // window registers
   bnnf_pkg::window_type       win_ff;
   bnnf_pkg::window_type       win_in;
   logic [bnnf_pkg::PIX_W-1:0] next_orig_ff;
   logic [2:0]                 top_bits;
   logic [2:0]                 mid_bits;
   logic [bnnf_pkg::PIX_W-1:0] filt_pix;

   assign top_bits    = s1_row_ff[0] ? slot1 : slot0;
   assign mid_bits    = s1_row_ff[0] ? slot0 : slot1;
   assign win_in.col0 = win_ff.col1;
   assign win_in.col1 = win_ff.col2;
   assign win_in.col2 = {s1_bin_ff, mid_bits, top_bits};
   assign win_in.orig = next_orig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         next_orig_ff <= '0;
      end else if (s1_adv) begin
         win_ff       <= win_in;
         next_orig_ff <= above_pix;
      end
   end

   bnnf_filter u_filter (
      .win      (win_in),
      .max_diff (max_diff_ff),
      .filtered (filt_pix)
   );

   // result bundle: up to three results of one pixel
   logic [2:0]                 bnd_mask_ff;
   logic [bnnf_pkg::PIX_W-1:0] bnd_mid_ff;
   logic [bnnf_pkg::PIX_W-1:0] bnd_edge_ff;
   logic [bnnf_pkg::PIX_W-1:0] bnd_pix_ff;
   logic [CW-1:0]              bnd_col_ff;
   logic [bnnf_pkg::ROW_W-1:0] bnd_row_ff;
   logic                       bnd_last_ff;
   logic [2:0]                 bnd_rest;
   logic                       out_free;
   logic                       bnd_emit;
   logic                       bnd_done;
   logic [2:0]                 mask_in;
   logic                       s1_interior;
   logic                       rsp_valid_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign bnd_emit  = (bnd_mask_ff != 3'd0) && out_free;
   assign bnd_rest  = bnd_mask_ff & (bnd_mask_ff - 3'd1);
   assign bnd_done  = (bnd_mask_ff == 3'd0) || (out_free && (bnd_rest == 3'd0));
   assign s1_adv    = s1_valid_ff && bnd_done;
   assign req_stall = s1_valid_ff && !bnd_done;

   assign s1_interior = (s1_col_ff >= CW'(2)) && (s1_row_ff >= 16'd2);
   assign mask_in[0]  = (s1_row_ff != '0) && (s1_col_ff != '0);
   assign mask_in[1]  = (s1_row_ff != '0) && (s1_col_ff == col_last);
   assign mask_in[2]  = (s1_row_ff == row_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_mask_ff <= '0;
      end else if (s1_adv) begin
         bnd_mask_ff <= mask_in;
      end else if (bnd_emit) begin
         bnd_mask_ff <= bnd_rest;
      end
      if (s1_adv) begin
         bnd_mid_ff  <= s1_interior ? filt_pix : next_orig_ff;
         bnd_edge_ff <= above_pix;
         bnd_pix_ff  <= s1_pix_ff;
         bnd_col_ff  <= s1_col_ff;
         bnd_row_ff  <= s1_row_ff;
         bnd_last_ff <= (s1_col_ff == col_last);
      end
   end

   // output register
   logic [bnnf_pkg::PIX_W-1:0] rsp_pix_ff;
   logic [CW-1:0]              rsp_col_ff;
   logic [bnnf_pkg::ROW_W-1:0] rsp_row_ff;
   logic                       rsp_last_ff;
   logic [bnnf_pkg::PIX_W-1:0] head_pix;
   logic [CW-1:0]              head_col;
   logic [bnnf_pkg::ROW_W-1:0] head_row;
   logic                       head_last;

   always_comb begin
      if (bnd_mask_ff[0]) begin
         head_pix  = bnd_mid_ff;
         head_col  = bnd_col_ff - CW'(1);
         head_row  = bnd_row_ff - 16'd1;
         head_last = 1'b0;
      end else if (bnd_mask_ff[1]) begin
         head_pix  = bnd_edge_ff;
         head_col  = bnd_col_ff;
         head_row  = bnd_row_ff - 16'd1;
         head_last = 1'b0;
      end else begin
         head_pix  = bnd_pix_ff;
         head_col  = bnd_col_ff;
         head_row  = bnd_row_ff;
         head_last = bnd_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= bnd_mask_ff != 3'd0;
      end
      if (bnd_emit) begin
         rsp_pix_ff  <= head_pix;
         rsp_col_ff  <= head_col;
         rsp_row_ff  <= head_row;
         rsp_last_ff <= head_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_pix_ff[7:0];
   assign rsp_out_green  = rsp_pix_ff[15:8];
   assign rsp_out_blue   = rsp_pix_ff[23:16];
   assign rsp_out_column = bnnf_pkg::COL_OUT_W'(rsp_col_ff);
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

FILE: hw/rtl/bnnf_checker.sv
// port-level assertions for the binary neighbour noise filter, bound to the top level
`include "binary_neighbour_noise_filter_top_assert.svh"

module bnnf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [bnnf_pkg::CH_W-1:0]      rsp_out_red,
   input logic [bnnf_pkg::CH_W-1:0]      rsp_out_green,
   input logic [bnnf_pkg::CH_W-1:0]      rsp_out_blue,
   input logic [bnnf_pkg::COL_OUT_W-1:0] rsp_out_column,
   input logic [bnnf_pkg::ROW_W-1:0]     rsp_out_row,
   input logic                           rsp_frame_last
);

   // a stalled transaction holds
   `BNNF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_out_column) && $stable(rsp_out_row) && $stable(rsp_frame_last))

   // reset empties the result side
   `BNNF_ASSERT_NOW(a_rsp_reset, clock, reset, $past(reset), !rsp_valid)

   // reset empties the pipeline, so input is taken at once
   `BNNF_ASSERT_NOW(a_req_reset, clock, reset, $past(reset), !req_stall)

   // the frame ends on a row no lower than the third
   `BNNF_ASSERT_NOW(a_last_row, clock, reset, rsp_valid && rsp_frame_last, rsp_out_row != 16'd0 && rsp_out_row != 16'd1)

endmodule

bind binary_neighbour_noise_filter_top bnnf_checker u_bnnf_checker (.*);
